// ===== rtl/encoder_count_extender_with_latch_top_macros.svh =====
// Assertion macros for the encoder count extender checker.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef ENCODER_COUNT_EXTENDER_WITH_LATCH_TOP_MACROS_SVH
`define ENCODER_COUNT_EXTENDER_WITH_LATCH_TOP_MACROS_SVH

// check a property outside of reset
`define ECX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property at every clock edge, reset included
`define ECX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ecx_pkg.sv =====
// Package for the encoder count extender: transaction payload types and
// status and control bit positions. No dependencies.
package ecx_pkg;

	localparam int unsigned ST_INPUT_BIT     = 5;
	localparam int unsigned ST_OVERFLOW_BIT  = 4;
	localparam int unsigned ST_UNDERFLOW_BIT = 3;
	localparam int unsigned ST_SET_ACK_BIT   = 2;
	localparam int unsigned ST_EXT_VALID_BIT = 1;
	localparam int unsigned ST_IDX_VALID_BIT = 0;

	localparam int unsigned CW_EXT_FALL_BIT = 3;
	localparam int unsigned CW_PRESET_BIT   = 2;
	localparam int unsigned CW_EXT_RISE_BIT = 1;
	localparam int unsigned CW_INDEX_BIT    = 0;

	typedef struct packed {
		logic               operational;
		logic [7:0]         status_byte;
		logic signed [15:0] counter_value;
		logic signed [15:0] latch_value;
		logic               reset_request;
		logic               arm_index;
		logic               arm_ext_rising;
		logic               arm_ext_falling;
		logic               set_count_request;
		logic signed [15:0] preset_value;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] total_count;
		logic signed [15:0] shown_raw_count;
		logic signed [15:0] shown_latch;
		logic [3:0]         control_word;
		logic signed [15:0] preset_out;
		logic               ext_input;
		logic               overflow_flag;
		logic               underflow_flag;
		logic               index_latch_valid;
		logic               ext_latch_valid;
	} result_t;

endpackage

// ===== rtl/ecx_core.sv =====
// Count extension state and next-state logic for one transaction.
// Depends on ecx_pkg.
module ecx_core import ecx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  sample_t sample,
	output result_t result
);

	logic [15:0] previous_raw_q;
	logic [31:0] extended_total_q;
	logic [15:0] held_raw_q;
	logic [15:0] held_latch_q;
	logic        index_armed_q;
	logic        ext_rising_armed_q;
	logic        ext_falling_armed_q;
	logic        preset_pending_q;
	logic        needs_init_q;
	logic        was_operational_q;

	logic [15:0] previous_raw_d;
	logic [31:0] extended_total_d;
	logic [15:0] held_raw_d;
	logic [15:0] held_latch_d;
	logic        index_armed_d;
	logic        ext_rising_armed_d;
	logic        ext_falling_armed_d;
	logic        preset_pending_d;
	logic        needs_init_d;
	logic        was_operational_d;

	logic        set_ack;
	logic        ext_valid;
	logic        idx_valid;
	logic        any_latch;
	logic        restart;
	logic [15:0] base_raw;
	logic [31:0] base_total;
	logic [15:0] step;
	logic [7:0]  shown_status;

	assign set_ack   = sample.status_byte[ST_SET_ACK_BIT];
	assign ext_valid = sample.status_byte[ST_EXT_VALID_BIT];
	assign idx_valid = sample.status_byte[ST_IDX_VALID_BIT];
	assign any_latch = ext_valid | idx_valid;
	assign restart   = needs_init_q | sample.reset_request;

	always_comb begin
		index_armed_d       = index_armed_q | sample.arm_index;
		ext_rising_armed_d  = ext_rising_armed_q | sample.arm_ext_rising;
		ext_falling_armed_d = ext_falling_armed_q | sample.arm_ext_falling;
		preset_pending_d    = preset_pending_q | sample.set_count_request;
		previous_raw_d      = previous_raw_q;
		extended_total_d    = extended_total_q;
		held_raw_d          = held_raw_q;
		held_latch_d        = held_latch_q;
		needs_init_d        = needs_init_q;
		was_operational_d   = 1'b0;
		shown_status        = 8'd0;
		base_raw            = previous_raw_q;
		base_total          = extended_total_q;
		step                = 16'd0;
		if (sample.operational) begin
			shown_status = sample.status_byte;
			if (set_ack) begin
				preset_pending_d = 1'b0;
			end
			if (!preset_pending_d) begin
				held_raw_d = sample.counter_value;
			end
			if (any_latch) begin
				base_raw = sample.latch_value;
			end else if (restart || set_ack || !was_operational_q) begin
				base_raw = sample.counter_value;
			end
			if (any_latch || restart) begin
				base_total = 32'd0;
			end
			if (any_latch) begin
				held_latch_d = sample.latch_value;
			end
			if (ext_valid) begin
				ext_rising_armed_d  = 1'b0;
				ext_falling_armed_d = 1'b0;
			end
			if (idx_valid) begin
				index_armed_d = 1'b0;
			end
			step              = sample.counter_value - base_raw;
			extended_total_d  = base_total + {{16{step[15]}}, step};
			previous_raw_d    = sample.counter_value;
			needs_init_d      = 1'b0;
			was_operational_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_raw_q      <= '0;
			extended_total_q    <= '0;
			held_raw_q          <= '0;
			held_latch_q        <= '0;
			index_armed_q       <= 1'b0;
			ext_rising_armed_q  <= 1'b0;
			ext_falling_armed_q <= 1'b0;
			preset_pending_q    <= 1'b0;
			needs_init_q        <= 1'b1;
			was_operational_q   <= 1'b0;
		end else if (advance) begin
			previous_raw_q      <= previous_raw_d;
			extended_total_q    <= extended_total_d;
			held_raw_q          <= held_raw_d;
			held_latch_q        <= held_latch_d;
			index_armed_q       <= index_armed_d;
			ext_rising_armed_q  <= ext_rising_armed_d;
			ext_falling_armed_q <= ext_falling_armed_d;
			preset_pending_q    <= preset_pending_d;
			needs_init_q        <= needs_init_d;
			was_operational_q   <= was_operational_d;
		end
	end

	always_comb begin
		result.total_count     = extended_total_d;
		result.shown_raw_count = held_raw_d;
		result.shown_latch     = held_latch_d;
		result.control_word    = '0;
		result.control_word[CW_EXT_FALL_BIT] = ext_falling_armed_d;
		result.control_word[CW_PRESET_BIT]   = preset_pending_d;
		result.control_word[CW_EXT_RISE_BIT] = ext_rising_armed_d;
		result.control_word[CW_INDEX_BIT]    = index_armed_d;
		result.preset_out        = sample.preset_value;
		result.ext_input         = shown_status[ST_INPUT_BIT];
		result.overflow_flag     = shown_status[ST_OVERFLOW_BIT];
		result.underflow_flag    = shown_status[ST_UNDERFLOW_BIT];
		result.index_latch_valid = shown_status[ST_IDX_VALID_BIT];
		result.ext_latch_valid   = shown_status[ST_EXT_VALID_BIT];
	end

endmodule

// ===== rtl/encoder_count_extender_with_latch_top.sv =====
// Top level of the encoder count extender: input register, result register
// and handshake. Depends on ecx_pkg and ecx_core.
//
//  channel  | valid         | ready         | payload
//  ---------+---------------+---------------+----------------
//  sample   | sample_valid  | sample_ready  | sample (sample_t)
//  result   | result_valid  | result_ready  | result (result_t)
//
// One transaction per clock sustained while result_ready is high; a result
// passes through the input register, then the result register, after its sample is accepted.
// The count update is one 16-bit subtract and one 32-bit add between them.
// arst_n clears both valid bits and sets the count state to its initial value.
// A stalled result holds; the input register still takes one more sample if it is empty.
module encoder_count_extender_with_latch_top import ecx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	sample_t sample_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t result_next;
	logic    advance;

	assign advance      = valid_s1 & (~valid_s2 | result_ready);
	assign sample_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (~valid_s2 | result_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	ecx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.sample (sample_s1),
		.result (result_next)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ===== rtl/ecx_checker.sv =====
// Port checker for the encoder count extender, bound to the top level.
// Depends on ecx_pkg and encoder_count_extender_with_latch_top_macros.svh.
`include "encoder_count_extender_with_latch_top_macros.svh"

module ecx_checker import ecx_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic latch_seen;
	logic arms_clear;
	logic total_rebased;

	assign latch_seen = result.index_latch_valid | result.ext_latch_valid;
	assign arms_clear = (!result.index_latch_valid || !result.control_word[CW_INDEX_BIT])
		&& (!result.ext_latch_valid || (!result.control_word[CW_EXT_RISE_BIT]
		&& !result.control_word[CW_EXT_FALL_BIT]));
	assign total_rebased = (&result.total_count[31:15]) | ~(|result.total_count[31:15]);

	`ECX_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid, "result dropped while stalled")
	`ECX_ASSERT(a_result_stable, result_valid && !result_ready |=> $stable(result), "stalled result changed")
	`ECX_ASSERT(a_ready_when_empty, !result_valid |-> sample_ready, "sample refused with empty output")
	`ECX_ASSERT(a_latch_disarms, result_valid && latch_seen |-> arms_clear, "latch left its arm flag set")
	`ECX_ASSERT(a_latch_rebase, result_valid && latch_seen |-> total_rebased, "total not rebased on latch")

endmodule

bind encoder_count_extender_with_latch_top ecx_checker u_ecx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_ready(sample_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
